// ===== hdl/srb_pkg.sv =====
// Shared types and constants of the segment reorder buffer.
// Used by the slot memory and the top level; depends on nothing.
package srb_pkg;

  // Field widths fixed by the segment descriptor format.
  localparam int SEQ_W = 31;
  localparam int LEN_W = 11;
  localparam int TAG_W = 16;
  localparam int KIND_W = 2;

  // Result kind codes.
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EOS = 2'd2;

  // One held segment descriptor as stored in a slot.
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } slot_t;

endpackage

// ===== hdl/segment_reorder_buffer.sv =====
// Segment reorder buffer: holds out-of-order segment descriptors in a slot memory
// and releases them in sequence order. An end-of-stream or out-of-window segment
// gives its result in the next cycle; one inside the window, held or refused for
// an occupied slot, gives it only after the slot index step. Each in-order
// release passes a slot read, then a match check; busy stays high until the last
// result. The receiver cannot stall. Synchronous reset clears the control state.
module segment_reorder_buffer #(
  parameter int WINDOW_SLOTS = 16,
  parameter int SEGMENT_BYTES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [srb_pkg::SEQ_W-1:0]   seq_number,
  input  logic [srb_pkg::LEN_W-1:0]   payload_length,
  input  logic [srb_pkg::TAG_W-1:0]   payload_tag,
  output logic                        busy,
  output logic                        strobe,
  output logic [srb_pkg::KIND_W-1:0]  result_kind,
  output logic [srb_pkg::TAG_W-1:0]   released_tag,
  output logic [srb_pkg::SEQ_W-1:0]   released_seq,
  output logic [srb_pkg::LEN_W-1:0]   released_length,
  output logic [srb_pkg::SEQ_W-1:0]   ack_number,
  output logic                        last_of_run
);

  localparam int LIMIT = WINDOW_SLOTS * SEGMENT_BYTES;
  localparam int REM_W = $clog2(LIMIT);
  localparam int IDX_W = $clog2(WINDOW_SLOTS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CHECK = 4'b1000
  } state_t;

  state_t                      state;
  logic [srb_pkg::SEQ_W-1:0]   expected_seq;
  logic [IDX_W-1:0]            window_head;
  logic [WINDOW_SLOTS-1:0]     slot_valid;
  logic [IDX_W-1:0]            drains;
  srb_pkg::slot_t              in_item;
  srb_pkg::slot_t              pend;
  srb_pkg::slot_t              rd_data;

  logic                        accept;
  logic [srb_pkg::SEQ_W-1:0]   seq_dist;
  logic                        in_window;
  logic                        div_start;
  logic                        div_done;
  logic [IDX_W-1:0]            quotient;
  logic [IDX_W:0]              slot_sum;
  logic [IDX_W-1:0]            hold_addr;
  logic                        wr_en;
  logic [IDX_W-1:0]            head_next;
  logic                        match;

  // Transfer of a new descriptor and its distance from the window base.
  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign seq_dist = seq_number - expected_seq;
  assign in_window = (seq_dist < srb_pkg::SEQ_W'(LIMIT));
  assign div_start = accept && (payload_length != '0) && (seq_number != expected_seq)
                     && in_window;

  // Ring position of the held segment's slot.
  assign slot_sum = {1'b0, window_head} + {1'b0, quotient};
  always_comb begin
    if (slot_sum >= (IDX_W + 1)'(WINDOW_SLOTS)) begin
      hold_addr = IDX_W'(slot_sum - (IDX_W + 1)'(WINDOW_SLOTS));
    end else begin
      hold_addr = slot_sum[IDX_W-1:0];
    end
  end
  assign wr_en = (state == ST_DIV) && div_done && !slot_valid[hold_addr];

  // Window head advance, wrapping at the slot count.
  assign head_next = (window_head == IDX_W'(WINDOW_SLOTS - 1)) ? '0
                     : window_head + IDX_W'(1);

  // A valid base slot at the expected sequence continues the run, up to a cap.
  assign match = slot_valid[window_head] && (rd_data.seq == expected_seq)
                 && (drains != IDX_W'(WINDOW_SLOTS - 1));

  srb_idx_div #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .SEGMENT_BYTES(SEGMENT_BYTES)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(seq_dist[REM_W-1:0]),
    .done    (div_done),
    .quotient(quotient)
  );

  srb_slot_mem #(
    .DEPTH(WINDOW_SLOTS),
    .AW   (IDX_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(hold_addr),
    .wr_data(in_item),
    .rd_addr(window_head),
    .rd_data(rd_data)
  );

  // Sequencer: window state, valid bits and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      expected_seq <= '0;
      window_head <= '0;
      slot_valid <= '0;
      drains <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (payload_length == '0) begin
              strobe <= 1'b1;
            end else if (seq_number == expected_seq) begin
              expected_seq <= expected_seq + srb_pkg::SEQ_W'(payload_length);
              slot_valid[window_head] <= 1'b0;
              window_head <= head_next;
              drains <= '0;
              state <= ST_READ;
            end else if (in_window) begin
              state <= ST_DIV;
            end else begin
              strobe <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (!slot_valid[hold_addr]) begin
              slot_valid[hold_addr] <= 1'b1;
            end
            strobe <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          strobe <= 1'b1;
          if (match) begin
            expected_seq <= expected_seq + srb_pkg::SEQ_W'(rd_data.len);
            slot_valid[window_head] <= 1'b0;
            window_head <= head_next;
            drains <= drains + IDX_W'(1);
            state <= ST_READ;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Input capture and the pending release that waits for its last flag.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_item.seq <= seq_number;
      in_item.len <= payload_length;
      in_item.tag <= payload_tag;
      pend.seq <= seq_number;
      pend.len <= payload_length;
      pend.tag <= payload_tag;
    end else if ((state == ST_CHECK) && match) begin
      pend <= rd_data;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    priority if ((state == ST_CHECK)) begin
      result_kind <= srb_pkg::KIND_RELEASE;
      released_tag <= pend.tag;
      released_seq <= pend.seq;
      released_length <= pend.len;
      ack_number <= match ? '0 : expected_seq;
      last_of_run <= !match;
    end else if (accept && (payload_length == '0)) begin
      result_kind <= srb_pkg::KIND_EOS;
      released_tag <= '0;
      released_seq <= '0;
      released_length <= '0;
      ack_number <= expected_seq;
      last_of_run <= 1'b1;
    end else begin
      result_kind <= srb_pkg::KIND_ACK;
      released_tag <= '0;
      released_seq <= '0;
      released_length <= '0;
      ack_number <= expected_seq;
      last_of_run <= 1'b1;
    end
  end

endmodule

// ===== hdl/srb_slot_mem.sv =====
// Slot memory of the segment reorder buffer: one descriptor per window slot.
// Synchronous write, registered read. Depends on srb_pkg.
module srb_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  srb_pkg::slot_t  wr_data,
  input  logic [AW-1:0]   rd_addr,
  output srb_pkg::slot_t  rd_data
);

  srb_pkg::slot_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/srb_idx_div.sv =====
// Slot index unit: distance divided by the segment size, found by comparing the
// distance with every slot boundary at once and registered. Depends on no package.
module srb_idx_div #(
  parameter int WINDOW_SLOTS = 16,
  parameter int SEGMENT_BYTES = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [$clog2(WINDOW_SLOTS*SEGMENT_BYTES)-1:0] dividend,
  output logic                            done,
  output logic [$clog2(WINDOW_SLOTS)-1:0] quotient
);

  localparam int LIMIT = WINDOW_SLOTS * SEGMENT_BYTES;
  localparam int REM_W = $clog2(LIMIT);
  localparam int IDX_W = $clog2(WINDOW_SLOTS);

  logic [IDX_W-1:0] q_next;

  // The quotient is the highest slot whose first byte lies at or below the distance.
  always_comb begin
    q_next = '0;
    for (int k = 1; k < WINDOW_SLOTS; k++) begin
      if (dividend >= REM_W'(k * SEGMENT_BYTES)) begin
        q_next = IDX_W'(k);
      end
    end
  end

  // Completion pulse in the cycle after the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // Quotient register, loaded on a request.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= q_next;
    end
  end

endmodule

// ===== test/tb_segment_reorder_buffer.sv =====
// Self-checking testbench of the segment reorder buffer top level.
// Depends on srb_pkg and segment_reorder_buffer; it predicts every result itself.
module tb_segment_reorder_buffer;
  timeunit 1ns;
  timeprecision 1ps;
  import srb_pkg::*;

  localparam int SLOTS = 16;
  localparam int SEG_BYTES = 1024;
  localparam int MAX_GAP = 13;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_ITEMS = 480;

  // One predicted or observed result transfer.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0] tag;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] ack;
    logic last;
  } seg_result_t;

  // One segment descriptor to be sent.
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } seg_desc_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [SEQ_W-1:0] seq_number = '0;
  logic [LEN_W-1:0] payload_length = '0;
  logic [TAG_W-1:0] payload_tag = '0;
  logic busy;
  logic strobe;
  logic [KIND_W-1:0] result_kind;
  logic [TAG_W-1:0] released_tag;
  logic [SEQ_W-1:0] released_seq;
  logic [LEN_W-1:0] released_length;
  logic [SEQ_W-1:0] ack_number;
  logic last_of_run;

  // Predicted receive state: next expected byte and the ring of held segments.
  logic [SEQ_W-1:0] rx_expected;
  int win_head;
  logic held_valid [SLOTS];
  logic [SEQ_W-1:0] held_seq [SLOTS];
  logic [LEN_W-1:0] held_len [SLOTS];
  logic [TAG_W-1:0] held_tag [SLOTS];

  seg_result_t expected_results [$];
  int errors = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;

  segment_reorder_buffer #(
    .WINDOW_SLOTS(SLOTS),
    .SEGMENT_BYTES(SEG_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .seq_number(seq_number),
    .payload_length(payload_length),
    .payload_tag(payload_tag),
    .busy(busy),
    .strobe(strobe),
    .result_kind(result_kind),
    .released_tag(released_tag),
    .released_seq(released_seq),
    .released_length(released_length),
    .ack_number(ack_number),
    .last_of_run(last_of_run)
  );

  always #6 clk = ~clk;

  // Moving the window discards logical slot 0 and opens an empty slot at the far end.
  task automatic slide_window();
    held_valid[win_head] = 1'b0;
    win_head = (win_head + 1) % SLOTS;
  endtask

  // Work out the results of one accepted segment and queue them.
  task automatic predict_segment(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                                 input logic [TAG_W-1:0] tag);
    seg_result_t run [$];
    seg_result_t r;
    logic [SEQ_W-1:0] seq_dist;
    int idx;
    int p;
    if (len == '0) begin
      r = '0;
      r.kind = KIND_EOS;
      run.push_back(r);
    end else if (seq == rx_expected) begin
      // In-order segment goes out first, then every held segment that now fits.
      r = '0;
      r.kind = KIND_RELEASE;
      r.tag = tag;
      r.seq = seq;
      r.len = len;
      run.push_back(r);
      rx_expected = rx_expected + len;
      slide_window();
      for (int k = 0; k < SLOTS - 1; k++) begin
        if (!held_valid[win_head] || held_seq[win_head] != rx_expected) break;
        r = '0;
        r.kind = KIND_RELEASE;
        r.tag = held_tag[win_head];
        r.seq = held_seq[win_head];
        r.len = held_len[win_head];
        run.push_back(r);
        rx_expected = rx_expected + held_len[win_head];
        slide_window();
      end
    end else begin
      // Segment ahead of the window base: hold it if its slot is in range and free.
      seq_dist = seq - rx_expected;
      idx = int'(seq_dist / SEG_BYTES);
      if (idx < SLOTS) begin
        p = (win_head + idx) % SLOTS;
        if (!held_valid[p]) begin
          held_valid[p] = 1'b1;
          held_seq[p] = seq;
          held_len[p] = len;
          held_tag[p] = tag;
        end
      end
    end
    if (run.size() == 0) begin
      r = '0;
      r.kind = KIND_ACK;
      run.push_back(r);
    end
    // The cumulative acknowledgement rides on the final result.
    r = run.pop_back();
    r.ack = rx_expected;
    r.last = 1'b1;
    run.push_back(r);
    foreach (run[i]) expected_results.push_back(run[i]);
  endtask

  // Send a segment after a random gap (none if no_gaps), predict it once busy is low.
  task automatic send_segment(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                              input logic [TAG_W-1:0] tag);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    seq_number <= seq;
    payload_length <= len;
    payload_tag <= tag;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_segment(seq, len, tag);
    items_sent++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Every result transfer is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    seg_result_t want;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: result kind %0h ack %0h arrived with nothing expected",
                 $time, result_kind, ack_number);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(result_kind));
        check_field("released_tag", 32'(want.tag), 32'(released_tag));
        check_field("released_seq", 32'(want.seq), 32'(released_seq));
        check_field("released_length", 32'(want.len), 32'(released_length));
        check_field("ack_number", 32'(want.ack), 32'(ack_number));
        check_field("last_of_run", 32'(want.last), 32'(last_of_run));
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // End of stream right after reset and with all sequence bits set.
  task automatic test_end_of_stream();
    send_segment('0, '0, '1);
    send_segment('1, '0, '0);
  endtask

  // Plain in-order segments, with the largest tag and the largest length.
  task automatic test_in_order();
    send_segment(rx_expected, LEN_W'(SEG_BYTES), '1);
    send_segment(rx_expected, '1, '0);
  endtask

  // An earlier segment and one just past the window are both dropped.
  task automatic test_drops();
    send_segment(rx_expected - 1'b1, 11'd100, 16'h1234);
    send_segment(rx_expected + SEQ_W'(SLOTS * SEG_BYTES), 11'd100, 16'h4321);
  endtask

  // Fill all slots but the base out of order, try a taken one, then drain the window.
  task automatic test_full_drain();
    logic [SEQ_W-1:0] base;
    base = rx_expected;
    for (int k = SLOTS - 1; k >= 1; k--)
      send_segment(base + SEQ_W'(k * SEG_BYTES), LEN_W'(SEG_BYTES), TAG_W'(16'hA000 + k));
    send_segment(base + SEQ_W'(3 * SEG_BYTES), 11'd7, 16'h5555);
    send_segment(base, LEN_W'(SEG_BYTES), 16'hA000);
  endtask

  // A mismatched held segment stops the drain and is later slid out of the window.
  task automatic test_drain_stop();
    logic [SEQ_W-1:0] base;
    base = rx_expected;
    send_segment(base + SEQ_W'(SEG_BYTES + 5), 11'd9, 16'h0F0F);
    send_segment(base + SEQ_W'(SLOTS * SEG_BYTES - 1), 11'd1, 16'hF0F0);
    send_segment(base, LEN_W'(SEG_BYTES), 16'h00FF);
    send_segment(rx_expected, 11'd5, 16'hFF00);
  endtask

  // Mostly shuffled bursts of consecutive segments, plus retransmits, holes and noise.
  task automatic test_random_traffic();
    seg_desc_t burst [$];
    seg_desc_t d;
    logic [SEQ_W-1:0] next_seq;
    int n;
    int j;
    int pick;
    bit full_size;
    while (items_sent < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_segment(SEQ_W'($urandom), LEN_W'($urandom_range(0, 2047)), TAG_W'($urandom));
      end else if (pick == 1) begin
        send_segment(SEQ_W'($urandom), '0, TAG_W'($urandom));
      end else begin
        burst.delete();
        n = $urandom_range(1, SLOTS);
        full_size = ($urandom_range(0, 9) < 7);
        next_seq = rx_expected;
        for (int k = 0; k < n; k++) begin
          d.seq = next_seq;
          if (full_size) d.len = LEN_W'(SEG_BYTES);
          else if ($urandom_range(0, 9) == 0) d.len = LEN_W'($urandom_range(1025, 2047));
          else d.len = LEN_W'($urandom_range(1, SEG_BYTES));
          d.tag = TAG_W'($urandom);
          burst.push_back(d);
          next_seq = next_seq + d.len;
        end
        // Shuffle, then sometimes add a retransmit or leave a hole.
        for (int k = n - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          d = burst[k];
          burst[k] = burst[j];
          burst[j] = d;
        end
        if ($urandom_range(0, 4) == 0) begin
          d = burst[$urandom_range(0, n - 1)];
          d.tag = TAG_W'($urandom);
          burst.push_back(d);
        end
        if (n > 1 && $urandom_range(0, 6) == 0) burst.delete($urandom_range(0, n - 1));
        foreach (burst[k]) send_segment(burst[k].seq, burst[k].len, burst[k].tag);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rx_expected = '0;
    win_head = 0;
    foreach (held_valid[i]) begin
      held_valid[i] = 1'b0;
      held_seq[i] = '0;
      held_len[i] = '0;
      held_tag[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_end_of_stream();
    test_in_order();
    test_drops();
    test_full_drain();
    test_drain_stop();
    test_random_traffic();

    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
